>>> rtl/time_text_to_minutes_parser_unit_defines.svh
// Assertion helpers for the parser RTL.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef TIME_TEXT_TO_MINUTES_PARSER_UNIT_DEFINES_SVH
`define TIME_TEXT_TO_MINUTES_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TTM_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define TTM_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/ttmp_pkg.sv
`default_nettype none
package ttmp_pkg;

  localparam int MAX_CHARS = 80;

  localparam logic [1:0] MODE_TOD   = 2'd0;
  localparam logic [1:0] MODE_MIL   = 2'd1;
  localparam logic [1:0] MODE_WORDS = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NONNUM = 3'd1;
  localparam logic [2:0] ST_MIN59  = 3'd2;
  localparam logic [2:0] ST_DIGITS = 3'd3;
  localparam logic [2:0] ST_SEC    = 3'd4;
  localparam logic [2:0] ST_BIG    = 3'd5;

  typedef enum logic [10:0] {
    PH_LEAD  = 11'b000_0000_0001,
    PH_WORD  = 11'b000_0000_0010,
    PH_HOURS = 11'b000_0000_0100,
    PH_MIN   = 11'b000_0000_1000,
    PH_SEC   = 11'b000_0001_0000,
    PH_SUF   = 11'b000_0010_0000,
    PH_TOK   = 11'b000_0100_0000,
    PH_ZSKIP = 11'b000_1000_0000,
    PH_ZONE  = 11'b001_0000_0000,
    PH_KW    = 11'b010_0000_0000,
    PH_DONE  = 11'b100_0000_0000
  } phase_t;

  // One classified character as the front hands it over.
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] lc;
    logic [3:0] dig;
    logic       is_digit;
    logic       is_space;
    logic       is_colon;
    logic       is_end;
    logic       last;
  } sym_t;

  // Parse state of one string.
  typedef struct packed {
    phase_t      phase;
    logic [15:0] hacc;
    logic [9:0]  hhi;
    logic [6:0]  macc;
    logic [1:0]  dcnt;
    logic [3:0]  kpos;
    logic [3:0]  cand;
    logic [2:0]  sflag;
    logic [1:0]  zsel;
    logic [2:0]  err;
    logic        sat;
  } ps_t;

  localparam sym_t SYM_END = '{ch: 8'd0, lc: 8'd0, dig: 4'd0, is_digit: 1'b0,
                               is_space: 1'b0, is_colon: 1'b0, is_end: 1'b1,
                               last: 1'b1};

  function automatic ps_t ps_clear();
    ps_t n;
    n = '0;
    n.phase = PH_LEAD;
    n.cand  = 4'hF;
    return n;
  endfunction

  function automatic ps_t ps_fin(ps_t s, logic [15:0] v, logic [2:0] st);
    ps_t n;
    n = s;
    n.err   = st;
    n.hacc  = (st != ST_OK) ? 16'd0 : v;
    n.phase = PH_DONE;
    return n;
  endfunction

  function automatic logic [7:0] word_char(logic mid, logic [3:0] pos);
    logic [7:0] c;
    c = 8'd0;
    if (mid) begin
      case (pos)
        4'd0: c = "m";
        4'd1: c = "i";
        4'd2: c = "d";
        4'd3: c = "n";
        4'd4: c = "i";
        4'd5: c = "g";
        4'd6: c = "h";
        4'd7: c = "t";
        default: c = 8'd0;
      endcase
    end else begin
      case (pos)
        4'd0: c = "n";
        4'd1: c = "o";
        4'd2: c = "o";
        4'd3: c = "n";
        default: c = 8'd0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] hour_char(logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0: c = "h";
      2'd1: c = "o";
      2'd2: c = "u";
      2'd3: c = "r";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Suffixes in try order: pm, p.m., a.m., am.
  function automatic logic [3:0] sfx_len(logic [1:0] i);
    logic [3:0] l;
    case (i)
      2'd0: l = 4'd2;
      2'd1: l = 4'd4;
      2'd2: l = 4'd4;
      2'd3: l = 4'd2;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] sfx_char(logic [1:0] i, logic [1:0] pos);
    logic [7:0] c;
    case ({i, pos})
      4'b00_00: c = "p";
      4'b00_01: c = "m";
      4'b01_00: c = "p";
      4'b01_01: c = ".";
      4'b01_10: c = "m";
      4'b01_11: c = ".";
      4'b10_00: c = "a";
      4'b10_01: c = ".";
      4'b10_10: c = "m";
      4'b10_11: c = ".";
      4'b11_00: c = "a";
      4'b11_01: c = "m";
      default:  c = 8'd0;
    endcase
    return c;
  endfunction

  // Hundreds digit of a value below 1000.
  function automatic logic [3:0] div100(logic [9:0] x);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 10'(k * 100)) q = 4'(k);
    end
    return q;
  endfunction

  // Advance the parse state by one symbol, following the forward chain
  // of phases that the same symbol may pass through.
  function automatic ps_t ps_feed(ps_t s, sym_t y, logic [1:0] mode);
    ps_t         n;
    logic        m0, m2, go_hr, go_kw, go_suf, go_z, nd, big, hit;
    logic [21:0] v, h60;
    logic [19:0] t;
    logic [9:0]  tt, r10;
    logic [3:0]  hi, cnd, lw;
    logic [1:0]  sel;
    logic [15:0] off;
    n      = s;
    m0     = (mode == MODE_TOD);
    m2     = (mode == MODE_WORDS);
    go_hr  = 1'b0;
    go_kw  = 1'b0;
    go_suf = 1'b0;
    go_z   = 1'b0;
    nd     = 1'b0;
    big    = 1'b0;
    hit    = 1'b0;
    v      = '0;
    h60    = '0;
    t      = '0;
    tt     = '0;
    r10    = '0;
    hi     = '0;
    cnd    = '0;
    lw     = '0;
    sel    = '0;
    off    = '0;

    if (s.phase == PH_LEAD) begin
      if (!y.is_space) begin
        if (y.is_end) begin
          n = ps_fin(n, 16'd0, ST_OK);
        end else if (y.is_digit) begin
          n.hacc  = '0;
          n.hhi   = '0;
          n.macc  = '0;
          n.sat   = 1'b0;
          n.phase = PH_HOURS;
          go_hr   = 1'b1;
        end else if (m0 && (y.lc == "n" || y.lc == "m")) begin
          n.cand  = {3'b000, (y.lc == "m")};
          n.kpos  = 4'd1;
          n.phase = PH_WORD;
        end else begin
          n = ps_fin(n, 16'd0, ST_NONNUM);
        end
      end
    end

    if (s.phase == PH_WORD) begin
      lw = s.cand[0] ? 4'd8 : 4'd4;
      if (s.kpos < lw && y.lc == word_char(s.cand[0], s.kpos)) begin
        if (s.kpos + 4'd1 >= lw) n = ps_fin(n, s.cand[0] ? 16'd1440 : 16'd720, ST_OK);
        else n.kpos = s.kpos + 4'd1;
      end else begin
        n = ps_fin(n, 16'd0, ST_NONNUM);
      end
    end

    if (s.phase == PH_HOURS || go_hr) begin
      if (y.is_digit) begin
        t = {4'b0, n.hacc} * 20'd10 + {16'b0, y.dig};
        if (t > 20'hFFFF) begin
          n.sat  = 1'b1;
          n.hacc = 16'hFFFF;
        end else begin
          n.hacc = t[15:0];
        end
        // Keep hours split as hundreds and last two digits.
        tt     = {3'b0, n.macc} * 10'd10 + {6'b0, y.dig};
        hi     = div100(tt);
        r10    = tt - {6'b0, hi} * 10'd100;
        n.macc = r10[6:0];
        n.hhi  = n.hhi * 10'd10 + {6'b0, hi};
      end else if (y.is_colon) begin
        n.macc  = '0;
        n.dcnt  = '0;
        n.phase = PH_MIN;
      end else if (m2) begin
        if (n.sat) begin
          n = ps_fin(n, 16'd0, ST_BIG);
        end else begin
          n.kpos  = '0;
          n.phase = PH_KW;
          go_kw   = 1'b1;
        end
      end else if (!n.sat && n.hacc != 16'd0 && n.hacc < 16'd24) begin
        nd = 1'b1;
        v  = {6'b0, n.hacc} * 22'd60;
      end else if (n.macc > 7'd59) begin
        n = ps_fin(n, 16'd0, ST_MIN59);
      end else begin
        nd  = 1'b1;
        v   = {12'b0, n.hhi} * 22'd60 + {15'b0, n.macc};
        big = n.sat;
      end
    end

    if (s.phase == PH_MIN) begin
      if (s.dcnt == 2'd0) begin
        if (!y.is_digit) begin
          n = ps_fin(n, 16'd0, ST_NONNUM);
        end else begin
          n.macc = {3'b0, y.dig};
          n.dcnt = 2'd1;
        end
      end else if (s.dcnt == 2'd1 && y.is_digit) begin
        n.macc = s.macc * 7'd10 + {3'b0, y.dig};
        n.dcnt = 2'd2;
      end else if (s.macc > 7'd59) begin
        n = ps_fin(n, 16'd0, ST_MIN59);
      end else if (y.is_digit) begin
        n = ps_fin(n, 16'd0, ST_DIGITS);
      end else if (y.is_colon) begin
        n.dcnt  = '0;
        n.phase = PH_SEC;
      end else begin
        nd  = 1'b1;
        v   = {6'b0, s.hacc} * 22'd60 + {15'b0, s.macc};
        big = s.sat;
      end
    end

    if (s.phase == PH_SEC) begin
      if (s.dcnt < 2'd2) begin
        if (!y.is_digit) n = ps_fin(n, 16'd0, ST_SEC);
        else n.dcnt = s.dcnt + 2'd1;
      end else if (y.is_digit) begin
        n = ps_fin(n, 16'd0, ST_SEC);
      end else begin
        nd  = 1'b1;
        v   = {6'b0, s.hacc} * 22'd60 + {15'b0, s.macc};
        big = s.sat;
      end
    end

    if (nd) begin
      if (big || v > 22'hFFFF) begin
        n = ps_fin(n, 16'd0, ST_BIG);
      end else if (!m0) begin
        n = ps_fin(n, v[15:0], ST_OK);
      end else if (v == 22'd0) begin
        n = ps_fin(n, 16'd0, ST_OK);
      end else if (v > 22'd1440) begin
        n = ps_fin(n, 16'd0, ST_BIG);
      end else begin
        n.hacc  = v[15:0];
        n.sflag = '0;
        n.phase = PH_SUF;
        go_suf  = 1'b1;
      end
    end

    if (s.phase == PH_KW || go_kw) begin
      if (!(n.kpos == 4'd0 && y.ch == " ")) begin
        if (n.kpos < 4'd4 && y.ch == hour_char(n.kpos[1:0])) begin
          if (n.kpos == 4'd3) begin
            h60 = {6'b0, n.hacc} * 22'd60;
            if (h60 > 22'hFFFF) n = ps_fin(n, 16'd0, ST_BIG);
            else n = ps_fin(n, h60[15:0], ST_OK);
          end else begin
            n.kpos = n.kpos + 4'd1;
          end
        end else begin
          n = ps_fin(n, n.hacc, ST_OK);
        end
      end
    end

    if (s.phase == PH_SUF || go_suf) begin
      if (!(n.sflag == 3'd0 && y.ch == " ")) begin
        cnd[0] = (n.sflag == 3'd0) && (y.lc == "p");
        cnd[1] = (n.sflag <= 3'd1) && (y.lc == "p");
        cnd[2] = (n.sflag <= 3'd2) && (y.lc == "a");
        cnd[3] = (n.sflag <= 3'd3) && (y.lc == "a");
        if (cnd != 4'd0) begin
          n.cand  = cnd;
          n.kpos  = 4'd1;
          n.phase = PH_TOK;
        end else begin
          n.phase = PH_ZSKIP;
          go_z    = 1'b1;
        end
      end
    end

    if (s.phase == PH_TOK) begin
      for (int i = 0; i < 4; i++) begin
        cnd[i] = s.cand[i] && (s.kpos < sfx_len(2'(i))) &&
                 (y.lc == sfx_char(2'(i), s.kpos[1:0]));
      end
      if (cnd == 4'd0) begin
        n = ps_fin(n, s.hacc, ST_OK);
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (!hit && cnd[i] && sfx_len(2'(i)) == s.kpos + 4'd1) begin
            hit = 1'b1;
            sel = 2'(i);
          end
        end
        if (hit) begin
          if (s.hacc >= 16'd780) begin
            n = ps_fin(n, 16'd0, ST_BIG);
          end else begin
            if (sel < 2'd2) begin
              if (s.hacc < 16'd720) n.hacc = s.hacc + 16'd720;
            end else begin
              if (s.hacc >= 16'd720) n.hacc = s.hacc - 16'd720;
            end
            n.sflag = {1'b0, sel} + 3'd1;
            n.phase = PH_SUF;
          end
        end else begin
          n.cand = cnd;
          n.kpos = s.kpos + 4'd1;
        end
      end
    end

    if (s.phase == PH_ZSKIP || go_z) begin
      if (y.ch != " ") begin
        if (y.lc == "m" || y.lc == "c" || y.lc == "e") begin
          n.zsel  = (y.lc == "m") ? 2'd1 : ((y.lc == "c") ? 2'd2 : 2'd3);
          n.kpos  = 4'd1;
          n.phase = PH_ZONE;
        end else begin
          n = ps_fin(n, n.hacc, ST_OK);
        end
      end
    end

    if (s.phase == PH_ZONE) begin
      if (s.kpos == 4'd1 && (y.lc == "d" || y.lc == "s")) begin
        n.kpos = 4'd2;
      end else if (s.kpos == 4'd2 && y.lc == "t") begin
        off = {14'b0, s.zsel} * 16'd60;
        n = ps_fin(n, (s.hacc >= off) ? s.hacc - off : s.hacc + 16'd1440 - off, ST_OK);
      end else begin
        n = ps_fin(n, s.hacc, ST_OK);
      end
    end

    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ttmp_front.sv
`default_nettype none
module ttmp_front import ttmp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  output logic            q_valid,
  output sym_t            q_sym,
  input  wire logic       q_pop
);

  localparam logic [6:0] CHAR_LIMIT = 7'(MAX_CHARS - 1);

  logic [6:0] ccnt_r, ccnt_nxt;
  sym_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic [7:0] ch;
  sym_t       sym;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_sym    = slot_r[rp_r];

  // A nul or an over-long string reads as end of text.
  always_comb begin
    ch = ((in_char == 8'd0) || (ccnt_r >= CHAR_LIMIT)) ? 8'd0 : in_char;
    sym.ch       = ch;
    sym.lc       = (ch inside {[8'h41:8'h5A]}) ? ch + 8'd32 : ch;
    sym.is_digit = (ch inside {[8'h30:8'h39]});
    sym.dig      = ch[3:0];
    sym.is_space = (ch == " ");
    sym.is_colon = (ch == ":");
    sym.is_end   = (ch == 8'd0);
    sym.last     = in_last;
  end

  always_comb begin
    ccnt_nxt = ccnt_r;
    if (push) begin
      if (in_last) ccnt_nxt = '0;
      else if (ccnt_r < CHAR_LIMIT) ccnt_nxt = ccnt_r + 7'd1;
    end
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      ccnt_r <= ccnt_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= sym;
  end

endmodule
`default_nettype wire

>>> rtl/ttmp_core.sv
`default_nettype none
module ttmp_core import ttmp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] mode,
  input  wire logic       q_valid,
  input  sym_t            q_sym,
  output logic            q_pop,
  output logic            snap_push,
  output ps_t             snap_data,
  input  wire logic       snap_ready
);

  ps_t st_r, st_nxt;
  ps_t fed;

  assign fed       = ps_feed(st_r, q_sym, mode);
  assign snap_data = fed;

  // Hand the state after the last character to the back stage, restart.
  always_comb begin
    q_pop     = q_valid && (!q_sym.last || snap_ready);
    snap_push = 1'b0;
    st_nxt    = st_r;
    if (q_pop) begin
      if (q_sym.last) begin
        snap_push = 1'b1;
        st_nxt    = ps_clear();
      end else begin
        st_nxt = fed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ps_clear();
    else st_r <= st_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/ttmp_out.sv
`default_nettype none
`include "time_text_to_minutes_parser_unit_defines.svh"
module ttmp_out import ttmp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  mode,
  input  wire logic        snap_push,
  input  ps_t              snap_data,
  output logic             snap_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_minutes,
  output logic [2:0]       out_status
);

  logic        snap_v_r, snap_v_nxt;
  ps_t         snap_r, snap_nxt;
  logic        out_v_r, out_v_nxt;
  logic [15:0] out_min_r, out_min_nxt;
  logic [2:0]  out_st_r, out_st_nxt;
  logic        out_load;
  ps_t         res;

  // Close the string with an end-of-text symbol.
  assign res        = ps_feed(snap_r, SYM_END, mode);
  assign out_load   = snap_v_r && (!out_v_r || out_ready);
  assign snap_ready = !snap_v_r || out_load;

  always_comb begin
    snap_v_nxt  = snap_v_r;
    snap_nxt    = snap_r;
    out_v_nxt   = out_v_r;
    out_min_nxt = out_min_r;
    out_st_nxt  = out_st_r;
    if (snap_ready) begin
      snap_v_nxt = snap_push;
      snap_nxt   = snap_data;
    end
    if (out_load) begin
      out_v_nxt   = 1'b1;
      out_min_nxt = res.hacc;
      out_st_nxt  = res.err;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r    <= snap_nxt;
    out_min_r <= out_min_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid   = out_v_r;
  assign out_minutes = out_min_r;
  assign out_status  = out_st_r;

  `TTM_ASSERT_IMP(a_err_zero, out_v_r && out_st_r != ST_OK, out_min_r == 16'd0, "error with minutes")
  `TTM_ASSERT_IMP(a_st_range, out_v_r, out_st_r <= ST_BIG, "status out of range")
  `TTM_ASSERT_NXT(a_load_shows, out_load, out_v_r, "loaded result not shown")

endmodule
`default_nettype wire

>>> rtl/time_text_to_minutes_parser_unit.sv
// Time text to minutes parser.
// in_*  : one character per item; in_tdata is the ASCII code, in_tlast marks
//         the final character of a string. One result item per string.
// out_* : out_tdata is the time in minutes, out_tuser the status
//         (0 ok, 1 non-numeric, 2 minutes over 59, 3 too many digits,
//         4 bad seconds, 5 too large). Minutes read 0 whenever status is not 0.
// cfg_* : parse mode write (0 time of day, 1 military interval, 2 interval
//         with hour words); write only while no string is in flight.
// Throughput: one character per cycle, strings back to back, while the result
// side takes results. The front classifies each character into a two-entry
// queue, the core updates the parse state once per character, and the back
// stage closes the string and holds the result register. The last
// character's parse state is registered as a snapshot before it is closed.
// When out_tready is low the result holds, the back stage and queue fill,
// then in_tready drops. Reset clears the queue, the parse state, the
// pending result and sets the mode to time of day.
`default_nettype none
module time_text_to_minutes_parser_unit import ttmp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] minutes_value
  output logic [2:0]       out_tuser,  // [2:0] status_code
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data    // [1:0] parse_mode
);

  logic [1:0] mode_r, mode_nxt;
  logic       q_valid, q_pop;
  sym_t       q_sym;
  logic       snap_push, snap_ready;
  ps_t        snap_data;

  // Always take mode writes.
  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? cfg_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_TOD;
    else mode_r <= mode_nxt;
  end

  ttmp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .q_valid  (q_valid),
    .q_sym    (q_sym),
    .q_pop    (q_pop)
  );

  ttmp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .q_valid    (q_valid),
    .q_sym      (q_sym),
    .q_pop      (q_pop),
    .snap_push  (snap_push),
    .snap_data  (snap_data),
    .snap_ready (snap_ready)
  );

  ttmp_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode        (mode_r),
    .snap_push   (snap_push),
    .snap_data   (snap_data),
    .snap_ready  (snap_ready),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_minutes (out_tdata),
    .out_status  (out_tuser)
  );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
  import ttmp_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int END_CODE   = 256;      // end-of-string symbol, outside the byte range
  localparam int TEXT_ITEMS = 350;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;         // [7:0] char_code
  logic        in_tlast = 1'b0;         // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;               // [15:0] minutes_value
  logic [2:0]  out_tuser;               // [2:0] status_code
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;         // [1:0] parse_mode

  time_text_to_minutes_parser_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  typedef struct packed {
    logic [15:0] minutes;
    logic [2:0]  status;
  } parse_result_t;

  parse_result_t pending_results[$];
  int  mismatches = 0;
  int  strings_sent = 0;
  int  chars_sent = 0;
  int  results_seen = 0;
  bit  steady_flow = 1'b0;   // when set, neither side idles
  int  quiet_cycles = 0;

  // Shadow copy of the parser state.
  logic [1:0]  mode_reg;
  phase_t      phase;
  logic [15:0] hours_acc;
  int          mins_acc;
  int          digit_cnt;
  int          word_pos;
  logic [7:0]  word_cand;
  int          suffix_seen;
  int          zone_sel;
  logic [2:0]  err_code;
  int          char_cnt;
  bit          hours_sat;

  string suffix_word[4] = '{"pm", "p.m.", "a.m.", "am"};
  int    suffix_size[4] = '{2, 4, 4, 2};

  function automatic bit is_num(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int fold_case(int c);
    return (c >= "A" && c <= "Z") ? c + 32 : c;
  endfunction

  function automatic int active_mode();
    return (mode_reg == 2'd3) ? int'(MODE_MIL) : int'(mode_reg);
  endfunction

  function automatic void reset_parse();
    phase = PH_LEAD;
    hours_acc = 0;
    mins_acc = 0;
    digit_cnt = 0;
    word_pos = 0;
    word_cand = 8'hFF;
    suffix_seen = 0;
    zone_sel = 0;
    err_code = ST_OK;
    char_cnt = 0;
    hours_sat = 1'b0;
  endfunction

  function automatic void settle(longint v, logic [2:0] st);
    err_code = st;
    hours_acc = (st != ST_OK) ? 16'd0 : v[15:0];
    phase = PH_DONE;
  endfunction

  // A complete number has been read: range checks, then suffix phase in time of day.
  function automatic void close_number(longint v, bit big);
    if (big || v > 65535) settle(0, ST_BIG);
    else if (active_mode() != MODE_TOD) settle(v, ST_OK);
    else if (v == 0) settle(0, ST_OK);
    else if (v > 1440) settle(0, ST_BIG);
    else begin
      hours_acc = v[15:0];
      suffix_seen = 0;
      phase = PH_SUF;
    end
  endfunction

  function automatic void close_military();
    longint h;
    h = hours_acc;
    if (active_mode() == MODE_WORDS) begin
      if (hours_sat) settle(0, ST_BIG);
      else begin
        word_pos = 0;
        phase = PH_KW;
      end
    end else if (!hours_sat && h > 0 && h < 24) close_number(h * 60, 1'b0);
    else if (mins_acc > 59) settle(0, ST_MIN59);
    else close_number((h / 100) * 60 + mins_acc, hours_sat);
  endfunction

  function automatic void take_suffix(int i);
    longint v;
    v = hours_acc;
    if (v >= 780) begin
      settle(0, ST_BIG);
      return;
    end
    if (i < 2) begin
      if (v < 720) v += 720;
    end else begin
      if (v >= 720) v -= 720;
    end
    hours_acc = v[15:0];
    suffix_seen = i + 1;
    phase = PH_SUF;
  endfunction

  // Advance the shadow parser by one symbol; some symbols pass through several phases.
  function automatic void parse_symbol(int c);
    bit     again;
    int     lc, pos, hits, wlen, d;
    longint t, off;
    string  w;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      lc = fold_case(c);
      pos = word_pos;
      case (phase)
        PH_LEAD: begin
          if (c == " ") ;
          else if (c == END_CODE) settle(0, ST_OK);
          else if (is_num(c)) begin
            hours_acc = 0;
            mins_acc = 0;
            hours_sat = 1'b0;
            phase = PH_HOURS;
            again = 1'b1;
          end else if (active_mode() == MODE_TOD && (lc == "n" || lc == "m")) begin
            word_cand = (lc == "m") ? 8'd1 : 8'd0;
            word_pos = 1;
            phase = PH_WORD;
          end else settle(0, ST_NONNUM);
        end
        PH_WORD: begin
          w = (word_cand != 0) ? "midnight" : "noon";
          wlen = w.len();
          if (pos < wlen && lc == w[pos]) begin
            pos++;
            if (pos >= wlen) settle((word_cand != 0) ? 1440 : 720, ST_OK);
            else word_pos = pos;
          end else settle(0, ST_NONNUM);
        end
        PH_HOURS: begin
          if (is_num(c)) begin
            d = c - "0";
            t = longint'(hours_acc) * 10 + d;
            if (t > 65535) begin
              hours_sat = 1'b1;
              t = 65535;
            end
            hours_acc = t[15:0];
            mins_acc = (mins_acc * 10 + d) % 100;
          end else if (c == ":") begin
            mins_acc = 0;
            digit_cnt = 0;
            phase = PH_MIN;
          end else begin
            close_military();
            again = 1'b1;
          end
        end
        PH_MIN: begin
          if (digit_cnt == 0) begin
            if (!is_num(c)) settle(0, ST_NONNUM);
            else begin
              mins_acc = c - "0";
              digit_cnt = 1;
            end
          end else if (digit_cnt == 1 && is_num(c)) begin
            mins_acc = mins_acc * 10 + (c - "0");
            digit_cnt = 2;
          end else if (mins_acc > 59) settle(0, ST_MIN59);
          else if (is_num(c)) settle(0, ST_DIGITS);
          else if (c == ":") begin
            digit_cnt = 0;
            phase = PH_SEC;
          end else begin
            close_number(longint'(hours_acc) * 60 + mins_acc, hours_sat);
            again = 1'b1;
          end
        end
        PH_SEC: begin
          if (digit_cnt < 2) begin
            if (!is_num(c)) settle(0, ST_SEC);
            else digit_cnt++;
          end else if (is_num(c)) settle(0, ST_SEC);
          else begin
            close_number(longint'(hours_acc) * 60 + mins_acc, hours_sat);
            again = 1'b1;
          end
        end
        PH_SUF: begin
          if (!(suffix_seen == 0 && c == " ")) begin
            hits = 0;
            for (int i = suffix_seen; i < 4; i++)
              if (lc == suffix_word[i][0]) hits |= 1 << i;
            if (hits != 0) begin
              word_cand = hits[7:0];
              word_pos = 1;
              phase = PH_TOK;
            end else begin
              phase = PH_ZSKIP;
              again = 1'b1;
            end
          end
        end
        PH_TOK: begin
          hits = 0;
          for (int i = 0; i < 4; i++)
            if (word_cand[i] && pos < suffix_size[i] && lc == suffix_word[i][pos & 3])
              hits |= 1 << i;
          if (hits == 0) settle(hours_acc, ST_OK);
          else begin
            d = -1;
            for (int i = 0; i < 4; i++)
              if (d < 0 && hits[i] && suffix_size[i] == pos + 1) d = i;
            if (d >= 0) take_suffix(d);
            else begin
              word_cand = hits[7:0];
              word_pos = pos + 1;
            end
          end
        end
        PH_ZSKIP: begin
          if (c != " ") begin
            if (lc == "m" || lc == "c" || lc == "e") begin
              zone_sel = (lc == "m") ? 1 : ((lc == "c") ? 2 : 3);
              word_pos = 1;
              phase = PH_ZONE;
            end else settle(hours_acc, ST_OK);
          end
        end
        PH_ZONE: begin
          if (pos == 1 && (lc == "d" || lc == "s")) word_pos = 2;
          else if (pos == 2 && lc == "t") begin
            off = 60 * zone_sel;
            settle((hours_acc >= off) ? hours_acc - off : hours_acc + 1440 - off, ST_OK);
          end else settle(hours_acc, ST_OK);
        end
        PH_KW: begin
          if (!(pos == 0 && c == " ")) begin
            w = "hour";
            if (pos < 4 && c == w[pos]) begin
              pos++;
              if (pos >= 4) begin
                t = longint'(hours_acc) * 60;
                if (t > 65535) settle(0, ST_BIG);
                else settle(t, ST_OK);
              end else word_pos = pos;
            end else settle(hours_acc, ST_OK);
          end
        end
        default: ;
      endcase
    end
  endfunction

  // Take one character; on the last one queue the expected result and start over.
  function automatic void predict_char(logic [7:0] ch, logic last);
    parse_result_t r;
    if (phase != PH_DONE) begin
      if (ch == 8'd0 || char_cnt >= MAX_CHARS - 1) parse_symbol(END_CODE);
      else begin
        char_cnt++;
        parse_symbol(int'(ch));
      end
    end
    if (last) begin
      if (phase != PH_DONE) parse_symbol(END_CODE);
      if (phase != PH_DONE) settle(hours_acc, ST_OK);
      r.minutes = hours_acc;
      r.status = err_code;
      pending_results.push_back(r);
      reset_parse();
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Model and scoreboard: sample handshakes with the values held before the edge.
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      mode_reg = 2'd0;
      reset_parse();
    end else begin
      if (cfg_valid && cfg_ready) mode_reg = cfg_data;
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, minutes", out_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata !== want.minutes) report_mismatch("minutes", out_tdata, want.minutes);
          if (out_tuser !== want.status) report_mismatch("status", out_tuser, want.status);
        end
      end
    end
  end

  // Result side back-pressure.
  int hold_cycles = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      hold_cycles <= pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if no handshake moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Send one item, hold it until taken, then idle for a random gap.
  task automatic send_char(logic [7:0] ch, logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    strings_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the mode only once the block has gone quiet.
  task automatic set_mode(logic [1:0] m);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic string digit_run(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  function automatic string flip_case(string s);
    string o;
    o = s;
    for (int i = 0; i < o.len(); i++)
      if (o[i] >= "a" && o[i] <= "z" && $urandom_range(0, 3) == 0) o[i] = o[i] - 32;
    return o;
  endfunction

  // Mostly well-formed times with random content, the rest noise and broken text.
  function automatic string random_text();
    string s, tails[8], zones[6];
    int    k;
    tails = '{"pm", "p.m.", "a.m.", "am", "p.x", "a", " hours", "hour"};
    zones = '{"edt", "est", "cdt", "cst", "mdt", "ez"};
    s = ($urandom_range(0, 4) == 0) ? " " : "";
    k = $urandom_range(0, 11);
    if (k == 0) begin
      for (int i = $urandom_range(1, 6); i > 0; i--)
        s = {s, string'(8'($urandom_range(0, 255)))};
      if (s.len() == 0) s = "x";
      return s;
    end
    if (k == 1) begin
      s = {s, flip_case($urandom_range(0, 1) ? "midnight" : "noon")};
      if ($urandom_range(0, 2) == 0) s = s.substr(0, $urandom_range(0, s.len() - 2));
      return (s.len() == 0) ? " " : s;
    end
    case ($urandom_range(0, 5))
      0: s = {s, $sformatf("%0d", $urandom_range(0, 23))};
      1: s = {s, $sformatf("%02d%02d", $urandom_range(0, 25), $urandom_range(0, 65))};
      2: s = {s, digit_run($urandom_range(5, 7))};
      default: s = {s, $sformatf("%0d:%02d", $urandom_range(0, 13), $urandom_range(0, 62))};
    endcase
    if ($urandom_range(0, 3) == 0) s = {s, $sformatf(":%02d", $urandom_range(0, 99))};
    if ($urandom_range(0, 9) == 0) s = {s, digit_run(1)};
    if ($urandom_range(0, 1)) s = {s, ($urandom_range(0, 1) ? " " : ""),
                                   flip_case(tails[$urandom_range(0, 7)])};
    if ($urandom_range(0, 2) == 0) s = {s, " ", flip_case(zones[$urandom_range(0, 5)])};
    if ($urandom_range(0, 5) == 0) s = {s, " x"};
    return s;
  endfunction

  task automatic test_time_of_day();
    set_mode(MODE_TOD);
    send_text("noon");
    send_text("MidNight");
    send_text("7");
    send_text("1230");
    send_text("0");
    send_text("12:30:45");
    send_text("3pm");
    send_text("3 p.m.");
    send_text("12 a.m.");
    send_text("12am");
    send_text("12:30 pm edt");
    send_text("1:00 am mst");
    send_text("0:30 cst");
  endtask

  task automatic test_errors();
    send_text("abc");
    send_text("12:60");
    send_text("12:345");
    send_text("1:x");
    send_text("12:30:4");
    send_text("13:00 pm");
    send_text("1441");
    send_text("9999999");
    send_text(" ");
    // A nul ends the string; a result settles and later text is dropped.
    send_char("1", 1'b0);
    send_char("2", 1'b0);
    send_char(8'd0, 1'b0);
    send_char("3", 1'b0);
    send_char("4", 1'b1);
    strings_sent++;
    send_text({"1", {90{"0"}}});
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_intervals();
    set_mode(MODE_MIL);
    send_text("0130");
    send_text("99999:00");
    set_mode(2'd3);
    send_text("23");
    set_mode(MODE_WORDS);
    send_text("5 hours");
    send_text("45");
    send_text("1093 hour");
    send_text("5 hx");
  endtask

  task automatic test_random_mix();
    int start;
    start = chars_sent;
    while (chars_sent - start < TEXT_ITEMS) begin
      set_mode(2'($urandom_range(0, 3)));
      steady_flow = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < 12; n++) send_text(random_text());
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_time_of_day();
    test_errors();
    test_intervals();
    test_random_mix();
    set_mode(MODE_TOD);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d strings (%0d characters) across all parse modes", strings_sent,
             chars_sent);
    $display("Checked %0d results, %0d mismatching fields", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
